@@ rtl/core/b64_pkg.sv @@
// shared types and alphabet helpers for the base64 stream codec
package b64_pkg;

    localparam int MaxRes = 4;

    localparam logic [7:0] PadChar = 8'h3D;

    localparam logic DirEncode = 1'b0;
    localparam logic DirDecode = 1'b1;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       last_out;
        logic       bad_char;
    } res_t;

    // group state carried between items
    typedef struct packed {
        logic [1:0] group_pos;
        logic [5:0] carry_bits;
        logic       pad_seen;
    } grp_t;

    // 6-bit index to alphabet character
    function automatic logic [7:0] sym(input logic [5:0] idx);
        logic [7:0] c;
        if (idx < 6'd26)
        begin
            c = 8'h41 + {2'b00, idx};
        end
        else if (idx < 6'd52)
        begin
            c = 8'h61 + {2'b00, idx} - 8'd26;
        end
        else if (idx < 6'd62)
        begin
            c = 8'h30 + {2'b00, idx} - 8'd52;
        end
        else if (idx == 6'd62)
        begin
            c = 8'h2B;
        end
        else
        begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // character to index, bit 6 set when outside the alphabet
    function automatic logic [6:0] char_index(input logic [7:0] c);
        logic [6:0] r;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = {1'b0, c[5:0] - 6'h01};
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            r = 7'(c - 8'h61 + 8'd26);
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            r = 7'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B)
        begin
            r = 7'd62;
        end
        else if (c == 8'h2F)
        begin
            r = 7'd63;
        end
        else
        begin
            r = 7'd64;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/base64_stream_codec.sv @@
// top level of the streaming base64 encoder/decoder
//
//  channel   signals                                   handshake
//  input     in_byte, last_in                          in_valid / in_ready
//  output    out_byte, has_data, last_out, bad_char    out_valid / out_ready
//  config    cfg_wdata (direction)                     cfg_we, no wait
//
// an accepted item is expanded into a batch of 1 to 4 results
// (or none for some decode inputs); results leave one per cycle via an
// output register unless out_ready stalls it; encode yields 4 symbols per 3 bytes.
// in_ready is high while the batch is empty or its last result is moving out.
// rst_n clears direction (encode), group state, batch count and output valid.
// a stall on out_ready holds the output register and backs up into in_ready.
module base64_stream_codec import b64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       last_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_data,
    output logic       last_out,
    output logic       bad_char
);

    logic              dir_reg;
    grp_t              grp_reg;
    grp_t              grp_next;
    res_t [MaxRes-1:0] batch_reg;
    res_t [MaxRes-1:0] batch_next;
    res_t [MaxRes-1:0] step_res;
    logic [2:0]        rem_reg;
    logic [2:0]        rem_next;
    logic [2:0]        step_cnt;
    logic              ovalid_reg;
    res_t              ores_reg;
    logic              accept;
    logic              move;

    // per-item logic
    b64_step u_step (
        .dir     (dir_reg),
        .in_byte (in_byte),
        .last_in (last_in),
        .st      (grp_reg),
        .st_next (grp_next),
        .res     (step_res),
        .res_cnt (step_cnt)
    );

    // handshake
    assign move     = (rem_reg != 3'd0) && (!ovalid_reg || out_ready);
    assign in_ready = (rem_reg == 3'd0) || (rem_reg == 3'd1 && move);
    assign accept   = in_valid && in_ready;

    // batch next value: load on accept, otherwise shift on move
    always_comb
    begin
        batch_next = batch_reg;
        rem_next   = rem_reg;
        if (accept)
        begin
            batch_next = step_res;
            rem_next   = step_cnt;
        end
        else if (move)
        begin
            for (int i = 0; i < MaxRes - 1; i++)
            begin
                batch_next[i] = batch_reg[i+1];
            end
            batch_next[MaxRes-1] = '0;
            rem_next             = rem_reg - 3'd1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg    <= DirEncode;
            grp_reg    <= '0;
            rem_reg    <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dir_reg <= cfg_wdata;
                grp_reg <= '0;
            end
            else if (accept)
            begin
                grp_reg <= grp_next;
            end
            rem_reg <= rem_next;
            if (move)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        batch_reg <= batch_next;
        if (move)
        begin
            ores_reg <= batch_reg[0];
        end
    end

    assign out_valid = ovalid_reg;
    assign out_byte  = ores_reg.out_byte;
    assign has_data  = ores_reg.has_data;
    assign last_out  = ores_reg.last_out;
    assign bad_char  = ores_reg.bad_char;

    // checks
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'd4)
        else $error("batch count out of range");

    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> rem_reg <= 3'd1)
        else $error("input taken with results still queued");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_in && !cfg_we) |=> grp_reg == '0)
        else $error("group state not cleared after final item");

    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_data) |-> (out_byte == 8'd0 && (last_out || bad_char)))
        else $error("marker item without a flag");

endmodule

@@ rtl/core/b64_step.sv @@
// per-item encode/decode logic: builds the result batch and next group state
module b64_step import b64_pkg::*;
(
    input  logic                    dir,
    input  logic [7:0]              in_byte,
    input  logic                    last_in,
    input  grp_t                    st,
    output grp_t                    st_next,
    output res_t [MaxRes-1:0]       res,
    output logic [2:0]              res_cnt
);

    logic [6:0] ci;
    logic       is_pad;
    logic       bad;
    logic [5:0] idx6;
    logic [1:0] pos_inc;

    assign ci     = char_index(in_byte);
    assign is_pad = (in_byte == PadChar);
    assign bad    = !is_pad && ci[6];
    assign idx6   = bad ? 6'd0 : ci[5:0];
    assign pos_inc = st.group_pos + 2'd1;

    always_comb
    begin
        st_next = st;
        res     = '0;
        res_cnt = 3'd0;
        if (dir == DirEncode)
        begin
            // emit the symbols this byte completes
            case (st.group_pos)
                2'd0:
                begin
                    res[0]             = '{sym(in_byte[7:2]), 1'b1, 1'b0, 1'b0};
                    res_cnt            = 3'd1;
                    st_next.carry_bits = {4'd0, in_byte[1:0]};
                    st_next.group_pos  = 2'd1;
                end
                2'd1:
                begin
                    res[0]             = '{sym({st.carry_bits[1:0], in_byte[7:4]}),
                                           1'b1, 1'b0, 1'b0};
                    res_cnt            = 3'd1;
                    st_next.carry_bits = {2'd0, in_byte[3:0]};
                    st_next.group_pos  = 2'd2;
                end
                default:
                begin
                    res[0]             = '{sym({st.carry_bits[3:0], in_byte[7:6]}),
                                           1'b1, 1'b0, 1'b0};
                    res[1]             = '{sym(in_byte[5:0]), 1'b1, 1'b0, 1'b0};
                    res_cnt            = 3'd2;
                    st_next.carry_bits = 6'd0;
                    st_next.group_pos  = 2'd0;
                end
            endcase
            // flush partial symbol and pad on the final byte
            if (last_in)
            begin
                if (st_next.group_pos == 2'd1)
                begin
                    res[1]  = '{sym({st_next.carry_bits[1:0], 4'd0}), 1'b1, 1'b0, 1'b0};
                    res[2]  = '{PadChar, 1'b1, 1'b0, 1'b0};
                    res[3]  = '{PadChar, 1'b1, 1'b1, 1'b0};
                    res_cnt = 3'd4;
                end
                else if (st_next.group_pos == 2'd2)
                begin
                    res[1]  = '{sym({st_next.carry_bits[3:0], 2'd0}), 1'b1, 1'b0, 1'b0};
                    res[2]  = '{PadChar, 1'b1, 1'b1, 1'b0};
                    res_cnt = 3'd3;
                end
                else
                begin
                    res[1].last_out = 1'b1;
                end
                st_next = '0;
            end
        end
        else
        begin
            // decode: assemble bytes from 6-bit indexes
            if (is_pad)
            begin
                st_next.pad_seen = 1'b1;
            end
            else if (!st.pad_seen)
            begin
                case (st.group_pos)
                    2'd0:
                    begin
                        st_next.carry_bits = idx6;
                    end
                    2'd1:
                    begin
                        res[0]             = '{{st.carry_bits, idx6[5:4]}, 1'b1, 1'b0, bad};
                        res_cnt            = 3'd1;
                        st_next.carry_bits = {2'd0, idx6[3:0]};
                    end
                    2'd2:
                    begin
                        res[0]             = '{{st.carry_bits[3:0], idx6[5:2]},
                                               1'b1, 1'b0, bad};
                        res_cnt            = 3'd1;
                        st_next.carry_bits = {4'd0, idx6[1:0]};
                    end
                    default:
                    begin
                        res[0]             = '{{st.carry_bits[1:0], idx6}, 1'b1, 1'b0, bad};
                        res_cnt            = 3'd1;
                        st_next.carry_bits = 6'd0;
                    end
                endcase
            end
            st_next.group_pos = pos_inc;
            if (pos_inc == 2'd0)
            begin
                st_next.carry_bits = 6'd0;
                st_next.pad_seen   = 1'b0;
            end
            // marker item when nothing else carries the flags
            if (res_cnt == 3'd0 && (last_in || bad))
            begin
                res[0]  = '{8'd0, 1'b0, 1'b0, bad};
                res_cnt = 3'd1;
            end
            if (last_in)
            begin
                res[0].last_out = 1'b1;
                st_next         = '0;
            end
        end
    end

endmodule
